>>> hdl/zfs_pkg.sv
// Shared types, constants and the arctangent table of the zonal flocking steering block.
package zfs_pkg;

   // parameter defaults
   localparam int DEF_MAX_NEIGHBOURS = 64;
   localparam int DEF_UNIT_FRAC_BITS = 14;
   localparam int DEF_CORDIC_STEPS   = 16;

   // fixed widths
   localparam int POS_W   = 16;
   localparam int ANG_W   = 16;
   localparam int RAD_W   = 15;
   localparam int SUM_W   = 22;
   localparam int CW      = 34;   // CORDIC and square root datapath width
   localparam int STEP_W  = 5;
   localparam int GUARD_BITS = 8;
   localparam int SQRT_STEPS = 17;
   localparam logic [63:0] K_Q30 = 64'd652032874;

   // register indexes
   localparam logic [2:0] REG_REPULSION   = 3'd0;
   localparam logic [2:0] REG_ORIENTATION = 3'd1;
   localparam logic [2:0] REG_ATTRACTION  = 3'd2;
   localparam logic [2:0] REG_HALF_VIEW   = 3'd3;
   localparam logic [2:0] REG_MAX_TURN    = 3'd4;
   localparam logic [2:0] REG_CRUISE      = 3'd5;

   // item kinds
   localparam logic ACT_OWN       = 1'b0;
   localparam logic ACT_NEIGHBOUR = 1'b1;

   // datapath operations
   typedef logic [3:0] op_type;
   localparam op_type OP_NOP        = 4'd0;
   localparam op_type OP_LOAD       = 4'd1;
   localparam op_type OP_MUL_X      = 4'd2;
   localparam op_type OP_MUL_Y      = 4'd3;
   localparam op_type OP_SQRT       = 4'd4;
   localparam op_type OP_VINIT_NB   = 4'd5;
   localparam op_type OP_VINIT_SUM  = 4'd6;
   localparam op_type OP_VEC_STEP   = 4'd7;
   localparam op_type OP_BEAR       = 4'd8;
   localparam op_type OP_RINIT_BEAR = 4'd9;
   localparam op_type OP_RINIT_HEAD = 4'd10;
   localparam op_type OP_ROT_STEP   = 4'd11;
   localparam op_type OP_UNIT       = 4'd12;
   localparam op_type OP_APPLY      = 4'd13;
   localparam op_type OP_ADD        = 4'd14;
   localparam op_type OP_FINAL      = 4'd15;

   typedef struct packed {
      op_type              op;
      logic [STEP_W-1:0]   step;
   } cmd_type;

   typedef struct packed {
      logic nb_full;
      logic dist_zero;
      logic need_head;
      logic out_busy;
   } stat_type;

   // arctangent of 2^-i as 32-bit binary angle
   function automatic logic [31:0] zfs_atan(input logic [STEP_W-1:0] idx);
      logic [31:0] a;
      unique case (idx)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

>>> hdl/zfs_if.sv
// Channel interfaces: pose requests, steering responses and register writes.
interface zfs_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [15:0] heading;
   logic        last;
   modport source (output valid, action, pos_x, pos_y, heading, last, input ready);
   modport sink   (input valid, action, pos_x, pos_y, heading, last, output ready);
endinterface

interface zfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] turn_command;
   logic [14:0] linear_command;
   modport source (output valid, turn_command, linear_command, input ready);
   modport sink   (input valid, turn_command, linear_command, output ready);
endinterface

interface zfs_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/zfs_ctrl.sv
// Sequencer that steps the datapath through square root, CORDIC and accumulate.
module zfs_ctrl #(
   parameter int CORDIC_STEPS = zfs_pkg::DEF_CORDIC_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_action,
   input  logic               req_last,
   output logic               req_ready,
   input  zfs_pkg::stat_type  stat,
   output zfs_pkg::cmd_type   cmd
);
   import zfs_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MULX   = 4'd1;
   localparam logic [3:0] S_MULY   = 4'd2;
   localparam logic [3:0] S_SQRT   = 4'd3;
   localparam logic [3:0] S_VINIT  = 4'd4;
   localparam logic [3:0] S_VEC    = 4'd5;
   localparam logic [3:0] S_BEAR   = 4'd6;
   localparam logic [3:0] S_RINIT  = 4'd7;
   localparam logic [3:0] S_ROT    = 4'd8;
   localparam logic [3:0] S_UNIT   = 4'd9;
   localparam logic [3:0] S_DECIDE = 4'd10;
   localparam logic [3:0] S_HINIT  = 4'd11;
   localparam logic [3:0] S_ADD    = 4'd12;
   localparam logic [3:0] S_SINIT  = 4'd13;
   localparam logic [3:0] S_FINAL  = 4'd14;

   localparam logic [STEP_W-1:0] LAST_ROT  = STEP_W'(CORDIC_STEPS - 1);
   localparam logic [STEP_W-1:0] LAST_SQRT = STEP_W'(SQRT_STEPS - 1);

   logic [3:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last_ff, last_in;
   logic              head_ff, head_in;
   logic              fin_ff, fin_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      last_in  = last_ff;
      head_in  = head_ff;
      fin_in   = fin_ff;
      cmd.op   = OP_NOP;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op  = OP_LOAD;
               last_in = req_last;
               if (req_action == ACT_NEIGHBOUR && !stat.nb_full) begin
                  state_in = S_MULX;
               end else if (req_last) begin
                  state_in = S_SINIT;
               end
            end
         end
         S_MULX: begin
            cmd.op   = OP_MUL_X;
            state_in = S_MULY;
         end
         S_MULY: begin
            cmd.op   = OP_MUL_Y;
            step_in  = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op  = OP_SQRT;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_SQRT) begin
               state_in = S_VINIT;
            end
         end
         S_VINIT: begin
            if (stat.dist_zero) begin
               state_in = S_DECIDE;
            end else begin
               cmd.op   = OP_VINIT_NB;
               step_in  = '0;
               fin_in   = 1'b0;
               state_in = S_VEC;
            end
         end
         S_VEC: begin
            cmd.op  = OP_VEC_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_ROT) begin
               state_in = fin_ff ? S_FINAL : S_BEAR;
            end
         end
         S_BEAR: begin
            cmd.op   = OP_BEAR;
            state_in = S_RINIT;
         end
         S_RINIT: begin
            cmd.op   = OP_RINIT_BEAR;
            step_in  = '0;
            head_in  = 1'b0;
            state_in = S_ROT;
         end
         S_ROT: begin
            cmd.op  = OP_ROT_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_ROT) begin
               state_in = S_UNIT;
            end
         end
         S_UNIT: begin
            cmd.op   = OP_UNIT;
            state_in = head_ff ? S_ADD : S_DECIDE;
         end
         S_DECIDE: begin
            cmd.op = OP_APPLY;
            if (stat.need_head) begin
               state_in = S_HINIT;
            end else begin
               state_in = last_ff ? S_SINIT : S_IDLE;
            end
         end
         S_HINIT: begin
            cmd.op   = OP_RINIT_HEAD;
            step_in  = '0;
            head_in  = 1'b1;
            state_in = S_ROT;
         end
         S_ADD: begin
            cmd.op   = OP_ADD;
            state_in = last_ff ? S_SINIT : S_IDLE;
         end
         S_SINIT: begin
            cmd.op   = OP_VINIT_SUM;
            step_in  = '0;
            fin_in   = 1'b1;
            state_in = S_VEC;
         end
         S_FINAL: begin
            // wait for the output word to drain
            if (!stat.out_busy) begin
               cmd.op   = OP_FINAL;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         last_ff  <= 1'b0;
         head_ff  <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         last_ff  <= last_in;
         head_ff  <= head_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

>>> hdl/zfs_datapath.sv
// Datapath: registers, square root, shared CORDIC, zone tests and sums.
module zfs_datapath #(
   parameter int MAX_NEIGHBOURS = zfs_pkg::DEF_MAX_NEIGHBOURS,
   parameter int UNIT_FRAC_BITS = zfs_pkg::DEF_UNIT_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  zfs_pkg::cmd_type  cmd,
   output zfs_pkg::stat_type stat,
   input  logic              req_action,
   input  logic [15:0]       req_pos_x,
   input  logic [15:0]       req_pos_y,
   input  logic [15:0]       req_heading,
   input  logic              csr_valid,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [15:0]       rsp_turn_command,
   output logic [14:0]       rsp_linear_command
);
   import zfs_pkg::*;

   localparam int UW  = UNIT_FRAC_BITS + 2;
   localparam int SH  = 30 - UNIT_FRAC_BITS - GUARD_BITS;
   localparam int NCW = $clog2(MAX_NEIGHBOURS + 1);
   localparam logic signed [CW-1:0] KINIT =
      $signed(CW'((K_Q30 + (64'd1 << (SH - 1))) >> SH));
   localparam logic signed [CW-1:0] GRND = CW'(1) <<< (GUARD_BITS - 1);

   // configuration
   logic [RAD_W-1:0] rep_ff, ori_ff, att_ff, cruise_ff;
   logic [ANG_W-1:0] half_ff, maxt_ff;

   // round state
   logic signed [POS_W-1:0] own_x_ff, own_y_ff;
   logic [ANG_W-1:0]        own_hd_ff, nb_hd_ff, bear_ff;
   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff, sum_x_in, sum_y_in;
   logic                    infl_ff, coll_ff, any_ff;
   logic [NCW-1:0]          cnt_ff;

   // neighbour working registers
   logic signed [POS_W:0]   dx_ff, dy_ff;
   logic [CW-1:0]           rem_ff, root_ff;
   logic signed [CW-1:0]    cx_ff, cy_ff;
   logic [31:0]             cz_ff;
   logic                    flip_ff;
   logic signed [UW-1:0]    ux_ff, uy_ff;

   // output word
   logic                    rv_ff;
   logic [ANG_W-1:0]        turn_ff;
   logic [RAD_W-1:0]        lin_ff;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [UW-1:0]    b,
      input logic                    sub
   );
      logic signed [SUM_W:0] t;
      t = sub ? (SUM_W+1)'(a) - (SUM_W+1)'(b) : (SUM_W+1)'(a) + (SUM_W+1)'(b);
      if (t[SUM_W] != t[SUM_W-1]) begin
         return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return t[SUM_W-1:0];
   endfunction

   // squaring and square root step
   logic [POS_W:0]   mul_a;
   logic [CW-1:0]    prod, sq_bit, sq_try;
   logic signed [POS_W:0] mul_src;
   assign mul_src = (cmd.op == OP_MUL_X) ? dx_ff : dy_ff;
   assign mul_a   = mul_src[POS_W] ? (POS_W+1)'(-mul_src) : mul_src;
   assign prod    = mul_a * mul_a;
   assign sq_bit  = CW'(1) << (6'd32 - {cmd.step, 1'b0});
   assign sq_try  = root_ff + sq_bit;

   // CORDIC micro-rotation
   logic [31:0]          atan_k;
   logic signed [CW-1:0] xs, ys;
   logic                 plus;
   assign atan_k = zfs_atan(cmd.step);
   assign xs     = cx_ff >>> cmd.step;
   assign ys     = cy_ff >>> cmd.step;
   assign plus   = (cmd.op == OP_VEC_STEP) ? (!cy_ff[CW-1] && cy_ff != '0) : cz_ff[31];

   // vectoring start values
   logic signed [CW-1:0] vx0, vy0;
   assign vx0 = (cmd.op == OP_VINIT_SUM) ? CW'(sum_x_ff) <<< 8 : CW'(dx_ff) <<< 8;
   assign vy0 = (cmd.op == OP_VINIT_SUM) ? CW'(sum_y_ff) <<< 8 : CW'(dy_ff) <<< 8;

   // rotation start angle
   logic [ANG_W-1:0] ra;
   logic             rflip;
   assign ra    = (cmd.op == OP_RINIT_HEAD) ? nb_hd_ff : bear_ff;
   assign rflip = (ra[15:14] == 2'd1) || (ra[15:14] == 2'd2);

   // rounded unit vector
   logic signed [CW-1:0] rx, ry;
   assign rx = (cx_ff + GRND) >>> GUARD_BITS;
   assign ry = (cy_ff + GRND) >>> GUARD_BITS;

   // zone tests
   logic                  dist_zero;
   logic [ANG_W-1:0]      gap;
   logic [ANG_W:0]        mag;
   logic                  in_view, repel, orient;
   logic signed [UW-1:0]  umx, umy;
   assign dist_zero = (root_ff == '0);
   assign gap    = dist_zero ? '0 : bear_ff - own_hd_ff;
   assign mag    = gap[15] ? (17'h10000 - {1'b0, gap}) : {1'b0, gap};
   assign repel  = root_ff <= CW'(rep_ff);
   assign orient = root_ff <= CW'(ori_ff);
   assign in_view = (root_ff <= CW'(att_ff)) && (mag <= {1'b0, half_ff});
   assign umx    = dist_zero ? '0 : ux_ff;
   assign umy    = dist_zero ? '0 : uy_ff;

   // final turn
   logic [31:0]           zr;
   logic [ANG_W-1:0]      tgap;
   logic signed [ANG_W+1:0] t18, m18;
   logic [ANG_W-1:0]      tsat;
   assign zr   = cz_ff + 32'h8000;
   assign tgap = zr[31:16] - own_hd_ff;
   assign t18  = (ANG_W+2)'($signed(tgap));
   assign m18  = $signed({2'b00, maxt_ff});
   always_comb begin
      if (t18 > m18) begin
         tsat = maxt_ff;
      end else if (t18 < -m18) begin
         tsat = ANG_W'(-m18);
      end else begin
         tsat = tgap;
      end
   end

   // sum update for apply and add
   always_comb begin
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      if (cmd.op == OP_APPLY && in_view) begin
         if (repel) begin
            sum_x_in = sat_add(sum_x_ff, umx, 1'b1);
            sum_y_in = sat_add(sum_y_ff, umy, 1'b1);
         end else if (!coll_ff && !orient) begin
            sum_x_in = sat_add(sum_x_ff, umx, 1'b0);
            sum_y_in = sat_add(sum_y_ff, umy, 1'b0);
         end
      end else if (cmd.op == OP_ADD) begin
         sum_x_in = sat_add(sum_x_ff, ux_ff, 1'b0);
         sum_y_in = sat_add(sum_y_ff, uy_ff, 1'b0);
      end
   end

   assign stat.nb_full   = cnt_ff >= NCW'(MAX_NEIGHBOURS);
   assign stat.dist_zero = dist_zero;
   assign stat.need_head = in_view && !repel && !coll_ff && orient;
   assign stat.out_busy  = rv_ff;

   assign rsp_valid          = rv_ff;
   assign rsp_turn_command   = turn_ff;
   assign rsp_linear_command = lin_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rep_ff    <= 15'd256;
         ori_ff    <= 15'd512;
         att_ff    <= 15'd3072;
         half_ff   <= 16'd24576;
         maxt_ff   <= 16'd7282;
         cruise_ff <= 15'd768;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_REPULSION:   rep_ff    <= csr_data[RAD_W-1:0];
            REG_ORIENTATION: ori_ff    <= csr_data[RAD_W-1:0];
            REG_ATTRACTION:  att_ff    <= csr_data[RAD_W-1:0];
            REG_HALF_VIEW:   half_ff   <= csr_data;
            REG_MAX_TURN:    maxt_ff   <= csr_data;
            REG_CRUISE:      cruise_ff <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // round state and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         own_x_ff  <= '0;
         own_y_ff  <= '0;
         own_hd_ff <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         infl_ff   <= 1'b0;
         coll_ff   <= 1'b0;
         any_ff    <= 1'b0;
         cnt_ff    <= '0;
         rv_ff     <= 1'b0;
      end else begin
         if (rv_ff && rsp_ready) begin
            rv_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_LOAD: begin
               if (req_action == ACT_OWN) begin
                  own_x_ff  <= $signed(req_pos_x);
                  own_y_ff  <= $signed(req_pos_y);
                  own_hd_ff <= req_heading;
                  sum_x_ff  <= '0;
                  sum_y_ff  <= '0;
                  infl_ff   <= 1'b0;
                  coll_ff   <= 1'b0;
                  any_ff    <= 1'b0;
                  cnt_ff    <= '0;
               end else if (!stat.nb_full) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            OP_APPLY: begin
               sum_x_ff <= sum_x_in;
               sum_y_ff <= sum_y_in;
               if (in_view) begin
                  infl_ff <= 1'b1;
                  if (repel) begin
                     coll_ff <= 1'b1;
                  end
               end
               if (!(in_view && (repel || coll_ff))) begin
                  any_ff <= 1'b1;
               end
            end
            OP_ADD: begin
               sum_x_ff <= sum_x_in;
               sum_y_ff <= sum_y_in;
            end
            OP_FINAL: begin
               rv_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // neighbour working registers and output payload
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            dx_ff    <= (POS_W+1)'($signed(req_pos_x)) - (POS_W+1)'(own_x_ff);
            dy_ff    <= (POS_W+1)'($signed(req_pos_y)) - (POS_W+1)'(own_y_ff);
            nb_hd_ff <= req_heading;
         end
         OP_MUL_X: begin
            rem_ff  <= prod;
            root_ff <= '0;
         end
         OP_MUL_Y: begin
            rem_ff <= rem_ff + prod;
         end
         OP_SQRT: begin
            if (rem_ff >= sq_try) begin
               rem_ff  <= rem_ff - sq_try;
               root_ff <= (root_ff >> 1) + sq_bit;
            end else begin
               root_ff <= root_ff >> 1;
            end
         end
         OP_VINIT_NB, OP_VINIT_SUM: begin
            if (vx0[CW-1]) begin
               cx_ff <= -vx0;
               cy_ff <= -vy0;
               cz_ff <= 32'h80000000;
            end else begin
               cx_ff <= vx0;
               cy_ff <= vy0;
               cz_ff <= '0;
            end
         end
         OP_VEC_STEP, OP_ROT_STEP: begin
            if (plus) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + atan_k;
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - atan_k;
            end
         end
         OP_BEAR: begin
            bear_ff <= zr[31:16];
         end
         OP_RINIT_BEAR, OP_RINIT_HEAD: begin
            cx_ff   <= KINIT;
            cy_ff   <= '0;
            cz_ff   <= {ra, 16'h0000} + (rflip ? 32'h80000000 : 32'h0);
            flip_ff <= rflip;
         end
         OP_UNIT: begin
            ux_ff <= flip_ff ? UW'(-rx) : UW'(rx);
            uy_ff <= flip_ff ? UW'(-ry) : UW'(ry);
         end
         OP_FINAL: begin
            turn_ff <= (infl_ff && (sum_x_ff != '0 || sum_y_ff != '0)) ? tsat : '0;
            lin_ff  <= any_ff ? cruise_ff : '0;
         end
         default: ;
      endcase
   end

endmodule

>>> hdl/zonal_flocking_steering_top.sv
// Top level of the zonal flocking steering block: sequencer plus datapath.
//
//   channel  dir  handshake        word
//   req_bus  in   valid / ready    action, pos_x, pos_y, heading, last
//   rsp_bus  out  valid / ready    turn_command, linear_command
//   csr_bus  in   valid / ready    index, data (ready is always high)
//
// An own pose is taken at load. A neighbour runs 17 square root steps
// plus a vectoring and a rotation pass of the shared CORDIC, and another
// rotation pass when it adds its heading vector.
// A last item adds a vectoring pass of the sum.
// Reset is synchronous and clears all control and round state.
// One item is in work at a time; the result sits in an output register, so
// the next item is taken while an earlier word waits on rsp_bus.
module zonal_flocking_steering_top #(
   parameter int MAX_NEIGHBOURS = zfs_pkg::DEF_MAX_NEIGHBOURS,
   parameter int UNIT_FRAC_BITS = zfs_pkg::DEF_UNIT_FRAC_BITS,
   parameter int CORDIC_STEPS   = zfs_pkg::DEF_CORDIC_STEPS
) (
   input  logic      clock,
   input  logic      reset,
   zfs_req_if.sink   req_bus,
   zfs_rsp_if.source rsp_bus,
   zfs_csr_if.sink   csr_bus
);
   import zfs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_bus.ready = 1'b1;

   zfs_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_last   (req_bus.last),
      .req_ready  (req_bus.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   zfs_datapath #(
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
      .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_action         (req_bus.action),
      .req_pos_x          (req_bus.pos_x),
      .req_pos_y          (req_bus.pos_y),
      .req_heading        (req_bus.heading),
      .csr_valid          (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_turn_command   (rsp_bus.turn_command),
      .rsp_linear_command (rsp_bus.linear_command)
   );

   // accept a request word only on the load command
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> (cmd.op == OP_LOAD))
      else $error("request accepted without load command");

   // never overwrite a pending result word
   a_final_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINAL) |-> !stat.out_busy)
      else $error("final issued while output busy");

   // a final command raises the result word next cycle
   a_final_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINAL) |=> rsp_bus.valid)
      else $error("result word missing after final");

endmodule
